/* sv/pps_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_ctrl, pps_dp and the preemptive_priority_scheduler top level.
package pps_pkg;

    // field widths
    localparam int ARR_W      = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int IDX_OUT_W  = 4;
    localparam int OUT_TIME_W = 21;

    // one input beat: a task to load
    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_length;
        logic [PRIO_W-1:0]  task_priority;
        logic               last_task;
    } t_task_in;

    // one output beat: the timing of one task
    typedef struct packed {
        logic [IDX_OUT_W-1:0]  task_index;
        logic [OUT_TIME_W-1:0] first_start;
        logic [OUT_TIME_W-1:0] finish_time;
        logic                  last_result;
    } t_task_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted task
        logic sched_init;  // clear time, flags and counters for a new schedule
        logic scan_clr;    // restart the task scan
        logic scan_run;    // step the task scan
        logic ready_mode;  // scan for ready task and next arrival, else for a preempter
        logic take_run;    // latch the most urgent ready task as running
        logic jump;        // move time to the earliest pending arrival
        logic fetch;       // read remaining work of the running task, mark its start
        logic apply;       // run until preemption or completion
        logic out_read;    // read the stored times of the current result
        logic out_pop;     // result beat taken
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;    // every entry has been compared
        logic ready_found;  // some arrived unfinished task exists
        logic last_finish;  // the apply step completes the final task
        logic out_last;     // current result is the final one
    } t_dp_sts;

endpackage

/* sv/pps_ctrl.sv */
// Sequencer for the preemptive priority scheduler: load, scan, dispatch, report.
// Depends on pps_pkg for the command and status structs.
module pps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pps_pkg::t_dp_cmd  o_cmd,
    input  pps_pkg::t_dp_sts  i_sts
);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_RSCAN = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_PSCAN = 7'b0001000,
        ST_APPLY = 7'b0010000,
        ST_ORD   = 7'b0100000,
        ST_OSEND = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.sched_init = 1'b1;
                        o_cmd.scan_clr   = 1'b1;
                        n_state          = ST_RSCAN;
                    end
                end
            end
            ST_RSCAN: begin
                o_cmd.scan_run   = 1'b1;
                o_cmd.ready_mode = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_clr = 1'b1;
                    if (i_sts.ready_found) begin
                        o_cmd.take_run = 1'b1;
                        n_state        = ST_FETCH;
                    end else begin
                        o_cmd.jump = 1'b1;
                        n_state    = ST_RSCAN;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_PSCAN;
            end
            ST_PSCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                if (i_sts.last_finish) begin
                    n_state = ST_ORD;
                end else begin
                    n_state = ST_RSCAN;
                end
            end
            ST_ORD: begin
                o_cmd.out_read = 1'b1;
                n_state        = ST_OSEND;
            end
            ST_OSEND: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_pop = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_ORD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

/* sv/pps_dp.sv */
// Datapath for the preemptive priority scheduler: task memories, scan compare,
// time keeping and result readout. Depends on pps_pkg for types and widths.
module pps_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_task_in  i_in_data,
    input  pps_pkg::t_dp_cmd   i_cmd,
    output pps_pkg::t_dp_sts   o_sts,
    output pps_pkg::t_task_out o_out_data
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    // arrival plus the sum of all bursts never reaches 2^TW
    localparam int TW = pps_pkg::ARR_W + CW;
    localparam int AW = pps_pkg::ARR_W;
    localparam int BW = pps_pkg::BURST_W;
    localparam int PW = pps_pkg::PRIO_W;
    localparam int OTW = pps_pkg::OUT_TIME_W;

    // task memories
    logic [AW-1:0]  r_arr_mem    [MAX_TASKS];
    logic [PW-1:0]  r_prio_mem   [MAX_TASKS];
    logic [BW-1:0]  r_rem_mem    [MAX_TASKS];
    logic [OTW-1:0] r_start_mem  [MAX_TASKS];
    logic [OTW-1:0] r_finish_mem [MAX_TASKS];

    // control state
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_finished;
    logic [TW-1:0]        r_time;
    logic [MAX_TASKS-1:0] r_done;
    logic [MAX_TASKS-1:0] r_started;
    logic [CW-1:0]        r_scan;
    logic                 r_pvld;
    logic                 r_rdy_found;
    logic                 r_arr_found;
    logic [IW-1:0]        r_k;

    // payload registers
    logic [IW-1:0]  r_pidx;
    logic [AW-1:0]  r_rd_arr;
    logic [PW-1:0]  r_rd_prio;
    logic [BW-1:0]  r_rem_rd;
    logic [OTW-1:0] r_start_rd;
    logic [OTW-1:0] r_finish_rd;
    logic [IW-1:0]  r_rdy_idx;
    logic [PW-1:0]  r_rdy_prio;
    logic [AW-1:0]  r_arr_best;
    logic [IW-1:0]  r_run;
    logic [PW-1:0]  r_run_prio;

    logic          w_load_wr;
    logic [IW-1:0] w_load_idx;
    logic          w_scan_issue;
    logic [IW-1:0] w_scan_idx;
    logic          w_p_done;
    logic [TW-1:0] w_p_arr;
    logic [TW-1:0] w_end;
    logic          w_rdy_hit;
    logic          w_arr_ok;
    logic          w_arr_hit;
    logic [TW-1:0] w_used;
    logic [BW-1:0] w_rem_new;
    logic          w_preempt;
    logic          w_rem_we;
    logic [IW-1:0] w_rem_addr;
    logic [BW-1:0] w_rem_wdata;

    // load and scan addressing
    always_comb begin
        w_load_wr    = i_cmd.load && (r_count < CW'(MAX_TASKS));
        w_load_idx   = r_count[IW-1:0];
        w_scan_issue = i_cmd.scan_run && (r_scan < r_count);
        w_scan_idx   = r_scan[IW-1:0];
    end

    // compare one scanned entry against the running bests
    always_comb begin
        w_p_done  = r_done[r_pidx];
        w_p_arr   = TW'(r_rd_arr);
        w_end     = r_time + TW'(r_rem_rd);
        w_rdy_hit = i_cmd.scan_run && r_pvld && i_cmd.ready_mode && !w_p_done
                    && (w_p_arr <= r_time)
                    && (!r_rdy_found || (r_rd_prio < r_rdy_prio));
        w_arr_ok  = i_cmd.ready_mode
                    || ((r_rd_prio < r_run_prio) && (w_p_arr < w_end));
        w_arr_hit = i_cmd.scan_run && r_pvld && !w_p_done && w_arr_ok
                    && (!r_arr_found || (r_rd_arr < r_arr_best));
    end

    // remaining work after a preemption, and the remaining-memory write port
    always_comb begin
        w_preempt   = r_arr_found;
        w_used      = TW'(r_arr_best) - r_time;
        w_rem_new   = r_rem_rd - w_used[BW-1:0];
        w_rem_we    = w_load_wr || (i_cmd.apply && w_preempt);
        w_rem_addr  = i_cmd.load ? w_load_idx : r_run;
        w_rem_wdata = i_cmd.load ? i_in_data.burst_length : w_rem_new;
    end

    // arrival and priority memory: load writes, scan reads
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_arr_mem[w_load_idx]  <= i_in_data.arrival_time;
            r_prio_mem[w_load_idx] <= i_in_data.task_priority;
        end
        if (w_scan_issue) begin
            r_rd_arr  <= r_arr_mem[w_scan_idx];
            r_rd_prio <= r_prio_mem[w_scan_idx];
        end
    end

    // remaining-work memory
    always_ff @(posedge i_clk) begin
        if (w_rem_we) begin
            r_rem_mem[w_rem_addr] <= w_rem_wdata;
        end
        if (i_cmd.fetch) begin
            r_rem_rd <= r_rem_mem[r_run];
        end
    end

    // first-start and finish memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && !r_started[r_run]) begin
            r_start_mem[r_run] <= OTW'(r_time);
        end
        if (i_cmd.apply && !w_preempt) begin
            r_finish_mem[r_run] <= OTW'(w_end);
        end
        if (i_cmd.out_read) begin
            r_start_rd  <= r_start_mem[r_k];
            r_finish_rd <= r_finish_mem[r_k];
        end
    end

    // hold the bests and the running task
    always_ff @(posedge i_clk) begin
        r_pidx <= w_scan_idx;
        if (w_rdy_hit) begin
            r_rdy_idx  <= r_pidx;
            r_rdy_prio <= r_rd_prio;
        end
        if (w_arr_hit) begin
            r_arr_best <= r_rd_arr;
        end
        if (i_cmd.take_run) begin
            r_run      <= r_rdy_idx;
            r_run_prio <= r_rdy_prio;
        end
    end

    // counters, flags and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_finished  <= '0;
            r_time      <= '0;
            r_done      <= '0;
            r_started   <= '0;
            r_scan      <= '0;
            r_pvld      <= 1'b0;
            r_rdy_found <= 1'b0;
            r_arr_found <= 1'b0;
            r_k         <= '0;
        end else begin
            // task count: advance on load, drop after the last result
            if (w_load_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.out_pop && o_sts.out_last) begin
                r_count <= '0;
            end

            // scan pointer and compare pipeline
            r_pvld <= w_scan_issue;
            if (i_cmd.scan_clr) begin
                r_scan      <= '0;
                r_rdy_found <= 1'b0;
                r_arr_found <= 1'b0;
            end else begin
                if (w_scan_issue) begin
                    r_scan <= r_scan + CW'(1);
                end
                if (w_rdy_hit) begin
                    r_rdy_found <= 1'b1;
                end
                if (w_arr_hit) begin
                    r_arr_found <= 1'b1;
                end
            end

            // schedule time, finished count, done and started flags, result index
            if (i_cmd.sched_init) begin
                r_time     <= '0;
                r_finished <= '0;
                r_done     <= '0;
                r_started  <= '0;
                r_k        <= '0;
            end else begin
                if (i_cmd.jump) begin
                    r_time <= TW'(r_arr_best);
                end
                if (i_cmd.fetch) begin
                    r_started[r_run] <= 1'b1;
                end
                if (i_cmd.apply) begin
                    if (w_preempt) begin
                        r_time <= TW'(r_arr_best);
                    end else begin
                        r_time         <= w_end;
                        r_done[r_run]  <= 1'b1;
                        r_finished     <= r_finished + CW'(1);
                    end
                end
                if (i_cmd.out_pop && !o_sts.out_last) begin
                    r_k <= r_k + IW'(1);
                end
            end
        end
    end

    // status to the controller
    always_comb begin
        o_sts.scan_done   = (r_scan == r_count) && !r_pvld;
        o_sts.ready_found = r_rdy_found;
        o_sts.last_finish = !r_arr_found && ((r_finished + CW'(1)) == r_count);
        o_sts.out_last    = (CW'(r_k) + CW'(1)) == r_count;
    end

    // result beat
    always_comb begin
        o_out_data.task_index  = pps_pkg::IDX_OUT_W'(r_k);
        o_out_data.first_start = r_start_rd;
        o_out_data.finish_time = r_finish_rd;
        o_out_data.last_result = o_sts.out_last;
    end

endmodule

/* sv/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: controller plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_dp.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | pps_pkg::t_task_in task
//   out     | output    | o_out_valid/i_out_stall | pps_pkg::t_task_out result
//
// A task beat that does not close a set is stored while the input stays open.
// The beat with last_task set starts the schedule: each decision runs a ready
// scan and a preemption scan over the N stored tasks, one entry per step through
// the single read port of the task memory; a set takes up to about 2N decisions,
// then each result beat is read from the result memories and then shown.
// Reset is synchronous and active low; no memory clearing pass is needed.
// The input stalls from the closing beat until the last result is taken; an
// output stall holds the result beat and the whole sequence.
module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pps_pkg::t_task_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pps_pkg::t_task_out o_out_data
);

    pps_pkg::t_dp_cmd w_cmd;
    pps_pkg::t_dp_sts w_sts;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_task),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pps_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

    // closing task beat never yields a result in the very next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last_task) |=> !o_out_valid)
        else $error("result beat right after closing task beat");

    // loading and reporting never overlap
    a_load_or_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("input open while a result is shown");

    // after the final result is taken the block takes tasks again
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_result) |=> !o_in_stall)
        else $error("input not reopened after final result");

    // dispatch, time jump and apply exclude each other
    a_dispatch_or_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.take_run, w_cmd.jump, w_cmd.apply}))
        else $error("conflicting scheduler commands");

endmodule
